FILE: rtl/trc_pkg.sv
// trc_pkg: shared types and constants of the tile map rectangle collision block.
// Payload structs, the queued operation, register codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  // holds tile counts up to the largest MAX_COLS / MAX_ROWS (1024)
  localparam int unsigned DIM_W      = 11;

  localparam logic [8:0] MAP_WIDTH_RST  = 9'd256;
  localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               command;
    logic [13:0]        tile_index;
    logic [7:0]         tile_id;
    logic signed [15:0] hit_left;
    logic signed [15:0] hit_top;
    logic signed [15:0] hit_right;
    logic signed [15:0] hit_bottom;
  } trc_in_t;

  typedef struct packed {
    logic        hit;
    logic [13:0] chip_left;
    logic [11:0] chip_top;
    logic [13:0] chip_right;
    logic [11:0] chip_bottom;
  } trc_out_t;

  typedef struct packed {
    logic               is_query;
    logic               wr_en;
    logic [13:0]        tile_index;
    logic [7:0]         tile_id;
    logic signed [15:0] hl;
    logic signed [15:0] ht;
    logic signed [15:0] hr;
    logic signed [15:0] hb;
    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   rows;
  } trc_op_t;

endpackage

`default_nettype wire

FILE: rtl/trc_front.sv
// trc_front: accepts input transactions and configuration writes, classifies them.
// Holds the map size registers, saturates them and range-checks tile writes.
// Depends on trc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trc_front import trc_pkg::*; #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire trc_in_t               in_data_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  clearing_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output trc_op_t                    q_data_o
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;

  logic [8:0] map_width_q, map_width_d;
  logic [6:0] map_height_q, map_height_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    map_width_d  = map_width_q;
    map_height_d = map_height_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MAP_WIDTH:  map_width_d  = cfg_data_i;
        CFG_MAP_HEIGHT: map_height_d = cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
    end else begin
      map_width_q  <= map_width_d;
      map_height_q <= map_height_d;
    end
  end

  assign in_ready_o = !q_full_i && !clearing_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_data_o.is_query   = (in_data_i.command == CMD_QUERY);
    q_data_o.wr_en      = (32'(in_data_i.tile_index) < DEPTH);
    q_data_o.tile_index = in_data_i.tile_index;
    q_data_o.tile_id    = in_data_i.tile_id;
    q_data_o.hl         = in_data_i.hit_left;
    q_data_o.ht         = in_data_i.hit_top;
    q_data_o.hr         = in_data_i.hit_right;
    q_data_o.hb         = in_data_i.hit_bottom;
    if (32'(map_width_q) > MAX_COLS) begin
      q_data_o.cols = DIM_W'(MAX_COLS);
    end else begin
      q_data_o.cols = DIM_W'(map_width_q);
    end
    if (32'(map_height_q) > MAX_ROWS) begin
      q_data_o.rows = DIM_W'(MAX_ROWS);
    end else begin
      q_data_o.rows = DIM_W'(map_height_q);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trc_fifo.sv
// trc_fifo: two-entry queue of classified operations between front and back.
// Depends on trc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trc_fifo import trc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire trc_op_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output trc_op_t      pop_data_o
);

  trc_op_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trc_back.sv
// trc_back: tile store, clearing pass, tile writes and the row-major query scan.
// Owns the result register. Fed by trc_fifo; depends on trc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trc_back import trc_pkg::*; #(
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned TILE_PIXELS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    op_valid_i,
  input  wire trc_op_t op_i,
  output logic         op_pop_o,
  output logic         clearing_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output trc_out_t     out_data_o
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PXW   = $clog2(MAX_COLS * TILE_PIXELS + TILE_PIXELS + 1);
  localparam int unsigned PYW   = $clog2(MAX_ROWS * TILE_PIXELS + TILE_PIXELS + 1);
  localparam int unsigned PMAX  = (PXW > PYW) ? PXW : PYW;
  localparam int unsigned CMPW  = ((PMAX > 16) ? PMAX : 16) + 1;
  localparam logic [PXW-1:0] TP_X   = PXW'(TILE_PIXELS);
  localparam logic [PYW-1:0] TP_Y   = PYW'(TILE_PIXELS);
  localparam logic [AW-1:0]  LAST_A = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } trc_state_e;

  trc_state_e state_q, state_d;

  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [DIM_W-1:0] x_q, x_d, y_q, y_d;
  logic [DIM_W-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [PXW-1:0]   px_q, px_d, s1_px_q, s1_px_d;
  logic [PYW-1:0]   py_q, py_d, s1_py_q, s1_py_d;
  logic             iss_q, iss_d;
  logic             s1_vld_q, s1_vld_d;
  logic             s1_last_q, s1_last_d;
  logic signed [15:0] hl_q, hl_d, ht_q, ht_d, hr_q, hr_d, hb_q, hb_d;
  logic             out_valid_q, out_valid_d;
  trc_out_t         out_q, out_d;
  logic             out_load;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;

  logic             row_end, last_issue, overlap, s1_hit;
  logic [PXW-1:0]   cr;
  logic [PYW-1:0]   cb;
  logic signed [CMPW-1:0] cl_s, cr_s, ct_s, cb_s, hl_s, ht_s, hr_s, hb_s;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  assign row_end    = (x_q == cols_q - DIM_W'(1));
  assign last_issue = row_end && (y_q == rows_q - DIM_W'(1));

  assign cr   = s1_px_q + TP_X;
  assign cb   = s1_py_q + TP_Y;
  assign cl_s = $signed({{(CMPW-PXW){1'b0}}, s1_px_q});
  assign cr_s = $signed({{(CMPW-PXW){1'b0}}, cr});
  assign ct_s = $signed({{(CMPW-PYW){1'b0}}, s1_py_q});
  assign cb_s = $signed({{(CMPW-PYW){1'b0}}, cb});
  assign hl_s = $signed({{(CMPW-16){hl_q[15]}}, hl_q});
  assign ht_s = $signed({{(CMPW-16){ht_q[15]}}, ht_q});
  assign hr_s = $signed({{(CMPW-16){hr_q[15]}}, hr_q});
  assign hb_s = $signed({{(CMPW-16){hb_q[15]}}, hb_q});

  assign overlap = (cl_s <= hr_s) && (ct_s <= hb_s) && (cr_s >= hl_s) && (cb_s >= ht_s);
  assign s1_hit  = s1_vld_q && (rdata_q != 8'd0) && overlap;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    addr_d      = addr_q;
    x_d         = x_q;
    y_d         = y_q;
    px_d        = px_q;
    py_d        = py_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    hl_d        = hl_q;
    ht_d        = ht_q;
    hr_d        = hr_q;
    hb_d        = hb_q;
    iss_d       = iss_q;
    s1_vld_d    = 1'b0;
    s1_last_d   = s1_last_q;
    s1_px_d     = s1_px_q;
    s1_py_d     = s1_py_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_load    = 1'b0;
    op_pop_o    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr_q;
    mem_wdata   = 8'd0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == LAST_A) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid_i) begin
          if (!op_i.is_query) begin
            op_pop_o  = 1'b1;
            mem_we    = op_i.wr_en;
            mem_waddr = AW'(op_i.tile_index);
            mem_wdata = op_i.tile_id;
          end else if (!out_valid_q) begin
            op_pop_o = 1'b1;
            cols_d   = op_i.cols;
            rows_d   = op_i.rows;
            hl_d     = op_i.hl;
            ht_d     = op_i.ht;
            hr_d     = op_i.hr;
            hb_d     = op_i.hb;
            addr_d   = '0;
            x_d      = '0;
            y_d      = '0;
            px_d     = '0;
            py_d     = '0;
            if ((op_i.cols == '0) || (op_i.rows == '0)) begin
              out_load = 1'b1;
              out_d    = '0;
            end else begin
              iss_d   = 1'b1;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          s1_vld_d  = 1'b1;
          s1_last_d = last_issue;
          s1_px_d   = px_q;
          s1_py_d   = py_q;
          addr_d    = addr_q + AW'(1);
          if (last_issue) begin
            iss_d = 1'b0;
          end else if (row_end) begin
            x_d  = '0;
            px_d = '0;
            y_d  = y_q + DIM_W'(1);
            py_d = py_q + TP_Y;
          end else begin
            x_d  = x_q + DIM_W'(1);
            px_d = px_q + TP_X;
          end
        end
        if (s1_hit) begin
          out_load          = 1'b1;
          out_d.hit         = 1'b1;
          out_d.chip_left   = 14'(s1_px_q);
          out_d.chip_top    = 12'(s1_py_q);
          out_d.chip_right  = 14'(cr);
          out_d.chip_bottom = 12'(cb);
          iss_d             = 1'b0;
          s1_vld_d          = 1'b0;
          state_d           = ST_IDLE;
        end else if (s1_vld_q && s1_last_q) begin
          out_load = 1'b1;
          out_d    = '0;
          s1_vld_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      iss_q       <= 1'b0;
      s1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      iss_q       <= iss_d;
      s1_vld_q    <= s1_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    x_q       <= x_d;
    y_q       <= y_d;
    px_q      <= px_d;
    py_q      <= py_d;
    cols_q    <= cols_d;
    rows_q    <= rows_d;
    hl_q      <= hl_d;
    ht_q      <= ht_d;
    hr_q      <= hr_d;
    hb_q      <= hb_d;
    s1_last_q <= s1_last_d;
    s1_px_q   <= s1_px_d;
    s1_py_q   <= s1_py_d;
    out_q     <= out_d;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("result loaded over a pending result");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !op_pop_o)
    else $error("operation taken during clearing pass");

  a_s1_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (state_q == ST_SCAN))
    else $error("read stage valid outside a scan");

endmodule

`default_nettype wire

FILE: rtl/tilemap_rect_collision_core.sv
// Tile map rectangle collision, top level.
// Input channel (in_valid_i/in_ready_o, in_data_i): command 0 writes tile_id at
// tile_index (ignored beyond the store), command 1 queries the rectangle
// hit_left/top/right/bottom. Writes give no output; each query gives one output
// transaction (out_valid_o/out_ready_i, out_data_o) with the first
// non-transparent tile, row-major, whose square touches the rectangle.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 map_width, 1 map_height;
// always ready; write only while idle.
// A query scans one tile per cycle out of a tile memory with one write and one read
// port once it leaves the two-entry queue, and stops early when a tile hits.
// After reset a clearing pass zeroes all MAX_COLS * MAX_ROWS entries of the store
// (16384 by default), with in_ready_o low; configuration writes still land.
// A stalled result sits in the output register; writes keep flowing behind it
// and the next query waits until the result is taken.
// Depends on trc_pkg, trc_front, trc_fifo, trc_back.
`timescale 1ns / 1ps
`default_nettype none

module tilemap_rect_collision_core import trc_pkg::*; #(
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned TILE_PIXELS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire trc_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output trc_out_t                   out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic    clearing;
  logic    q_full, q_push, q_valid, q_pop;
  trc_op_t q_in, q_out;

  trc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  trc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  trc_back #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_out),
    .op_pop_o    (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: dv/tilemap_rect_collision_checker.sv
// Scoreboard for tilemap_rect_collision_core: follows the config, input and
// output channels, keeps its own tile map and predicts each query's result.
// Depends on trc_pkg for the payload structs and register codes.
`timescale 1ns / 1ps

module tilemap_rect_collision_checker import trc_pkg::*; #(
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned TILE_PIXELS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  trc_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  trc_out_t              out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    queries_o,
  output int                    hits_o
);

  localparam int unsigned STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int          MAX_REPORTS = 10;

  logic [7:0] tile_map [STORE_DEPTH];
  logic [8:0] map_width;
  logic [6:0] map_height;
  trc_out_t   expected_hits [$];

  function automatic trc_out_t first_touching_tile(trc_in_t req);
    int       cols, rows, x, y, hl, ht, hr, hb, cl, ct, cr, cb;
    trc_out_t res;
    res  = '0;
    cols = (map_width > MAX_COLS) ? MAX_COLS : int'(map_width);
    rows = (map_height > MAX_ROWS) ? MAX_ROWS : int'(map_height);
    hl   = $signed(req.hit_left);
    ht   = $signed(req.hit_top);
    hr   = $signed(req.hit_right);
    hb   = $signed(req.hit_bottom);
    for (y = 0; y < rows; y++) begin
      for (x = 0; x < cols; x++) begin
        if (tile_map[x + y * cols] != 8'd0) begin
          cl = int'(x * TILE_PIXELS);
          ct = int'(y * TILE_PIXELS);
          cr = cl + int'(TILE_PIXELS);
          cb = ct + int'(TILE_PIXELS);
          if (!(cl > hr || ct > hb || cr < hl || cb < ht)) begin
            res.hit         = 1'b1;
            res.chip_left   = 14'(cl);
            res.chip_top    = 12'(ct);
            res.chip_right  = 14'(cr);
            res.chip_bottom = 12'(cb);
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trc_out_t want;
    if (!rst_ni) begin
      foreach (tile_map[i]) tile_map[i] = 8'd0;
      map_width    = MAP_WIDTH_RST;
      map_height   = MAP_HEIGHT_RST;
      expected_hits.delete();
      fail_count_o = 0;
      queries_o    = 0;
      hits_o       = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAP_WIDTH:  map_width = cfg_data_i[8:0];
          CFG_MAP_HEIGHT: map_height = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        queries_o++;
        if (out_data_i.hit) hits_o++;
        if (expected_hits.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("unexpected result: hit=%0b l=%0d t=%0d r=%0d b=%0d",
                     out_data_i.hit, out_data_i.chip_left, out_data_i.chip_top,
                     out_data_i.chip_right, out_data_i.chip_bottom);
        end else begin
          want = expected_hits.pop_front();
          if (want.hit != out_data_i.hit || want.chip_left != out_data_i.chip_left ||
              want.chip_top != out_data_i.chip_top ||
              want.chip_right != out_data_i.chip_right ||
              want.chip_bottom != out_data_i.chip_bottom) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display("mismatch: expected hit=%0b l=%0d t=%0d r=%0d b=%0d,",
                       want.hit, want.chip_left, want.chip_top, want.chip_right,
                       want.chip_bottom,
                       " got hit=%0b l=%0d t=%0d r=%0d b=%0d",
                       out_data_i.hit, out_data_i.chip_left,
                       out_data_i.chip_top, out_data_i.chip_right, out_data_i.chip_bottom);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.command == CMD_QUERY)
          expected_hits.push_back(first_touching_tile(in_data_i));
        else
          tile_map[in_data_i.tile_index] = in_data_i.tile_id;
      end
    end
    pending_o = expected_hits.size();
  end

endmodule

FILE: dv/tilemap_rect_collision_core_test.sv
// Testbench top for tilemap_rect_collision_core: drives tile writes, queries and
// map size registers with random idling and a long output stall.
// Depends on trc_pkg, the core RTL and tilemap_rect_collision_checker.
`timescale 1ns / 1ps

module tilemap_rect_collision_core_test;
  import trc_pkg::*;

  localparam int unsigned MAX_COLS      = 256;
  localparam int unsigned MAX_ROWS      = 64;
  localparam int unsigned TILE_PIXELS   = 32;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  trc_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  trc_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic        in_taken, cfg_taken;
  logic        hold_request, holding;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned cur_cols, cur_rows;
  int          items_sent, reg_writes;
  int          fail_count, pending, queries, hits;

  tilemap_rect_collision_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tilemap_rect_collision_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .queries_o    (queries),
    .hits_o       (hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tilemap_rect_collision_core test failed");
    $finish;
  end

  always @(posedge clk) begin
    in_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  always @(negedge clk) begin
    out_ready <= !holding && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // long output stall so the queue fills and input backpressure shows up
  initial begin
    holding = 1'b0;
    wait (hold_request);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding = 1'b0;
  end

  task automatic send_item(input trc_in_t item);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_taken);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
    wait_idle();
    write_reg(CFG_MAP_WIDTH, width);
    write_reg(CFG_MAP_HEIGHT, height);
    cur_cols = (width > MAX_COLS) ? MAX_COLS : width;
    cur_rows = (height[6:0] > MAX_ROWS) ? MAX_ROWS : height[6:0];
  endtask

  function automatic trc_in_t noise_item();
    trc_in_t item;
    item.command    = ($urandom_range(1, 0) == 1) ? CMD_QUERY : CMD_WRITE;
    item.tile_index = 14'($urandom);
    item.tile_id    = 8'($urandom);
    item.hit_left   = 16'($urandom);
    item.hit_top    = 16'($urandom);
    item.hit_right  = 16'($urandom);
    item.hit_bottom = 16'($urandom);
    return item;
  endfunction

  function automatic trc_in_t tile_write(input int unsigned idx, input logic [7:0] id);
    trc_in_t item;
    item            = noise_item();
    item.command    = CMD_WRITE;
    item.tile_index = 14'(idx);
    item.tile_id    = id;
    return item;
  endfunction

  function automatic trc_in_t rect_query(input int l, input int t, input int r, input int b);
    trc_in_t item;
    item            = noise_item();
    item.command    = CMD_QUERY;
    item.hit_left   = 16'(l);
    item.hit_top    = 16'(t);
    item.hit_right  = 16'(r);
    item.hit_bottom = 16'(b);
    return item;
  endfunction

  task automatic random_phase(input int unsigned n_items, input logic with_hold);
    int unsigned pick, span_x, span_y;
    int          l, t;
    trc_in_t     item;
    span_x = cur_cols * TILE_PIXELS + 64;
    span_y = cur_rows * TILE_PIXELS + 64;
    if (with_hold) hold_request = 1'b1;
    repeat (n_items) begin
      pick = $urandom_range(99, 0);
      item = noise_item();
      if (pick < 40) begin
        item.command = CMD_WRITE;
        if (cur_cols * cur_rows != 0)
          item.tile_index = 14'($urandom_range(cur_cols * cur_rows - 1, 0));
        if ($urandom_range(3, 0) == 0) item.tile_id = 8'd0;
      end else if (pick < 48) begin
        item.command = CMD_WRITE;
      end else if (pick < 90) begin
        l = int'($urandom_range(span_x, 0)) - 32;
        t = int'($urandom_range(span_y, 0)) - 32;
        if (pick < 84)
          item = rect_query(l, t, l + int'($urandom_range(70, 0)),
                            t + int'($urandom_range(70, 0)));
        else
          item = rect_query(l, t, l - int'($urandom_range(40, 1)),
                            t - int'($urandom_range(40, 0)));
      end else begin
        item.command = CMD_QUERY;
      end
      send_item(item);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_MAP_WIDTH;
    cfg_data      = '0;
    hold_request  = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 59;
    items_sent    = 0;
    reg_writes    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // full-size map, written while the store is still being cleared
    write_reg(CFG_MAP_WIDTH, 9'd256);
    write_reg(CFG_MAP_HEIGHT, 9'd64);
    cur_cols = MAX_COLS;
    cur_rows = MAX_ROWS;
    send_item(rect_query(-32768, -32768, 32767, 32767));
    send_item(tile_write(16383, 8'hFF));
    send_item(rect_query(-32768, -32768, 32767, 32767));
    send_item(tile_write(0, 8'h80));
    send_item(rect_query(32, 32, 32, 32));
    send_item(tile_write(0, 8'h00));

    // 2x2 map: inclusive edges, transparent tiles, inverted rectangles
    reconfigure(9'd2, 9'd2);
    send_item(tile_write(0, 8'h01));
    send_item(tile_write(1, 8'h00));
    send_item(tile_write(2, 8'h00));
    send_item(tile_write(3, 8'h7F));
    send_item(rect_query(-5, -5, -1, -1));
    send_item(rect_query(-5, -5, 0, 0));
    send_item(rect_query(64, 64, 70, 70));
    send_item(rect_query(65, 65, 70, 70));
    send_item(rect_query(10, 10, 5, 5));
    send_item(rect_query(40, 40, 20, 20));
    send_item(rect_query(33, 0, 40, 20));

    // zero sizes scan nothing
    reconfigure(9'd0, 9'd64);
    send_item(rect_query(-32768, -32768, 32767, 32767));
    reconfigure(9'd1, 9'd0);
    send_item(rect_query(-32768, -32768, 32767, 32767));

    // oversized registers saturate to the store dimensions
    reconfigure(9'd511, 9'h1FF);
    send_item(tile_write(256, 8'h42));
    send_item(rect_query(1, 33, 30, 60));
    reconfigure(9'd1, 9'd1);
    send_item(rect_query(-32768, -32768, 32767, 32767));

    reconfigure(9'd8, 9'd4);
    random_phase(17, 1'b0);
    reconfigure(9'd1, 9'd1);
    write_reg(CFG_IDX_SPARE_A, 9'h1FF);
    write_reg(CFG_IDX_SPARE_B, 9'h000);
    random_phase(16, 1'b0);

    wait_idle();
    send_idle_pct = 59;
    recv_idle_pct = 35;
    reconfigure(9'd16, 9'd8);
    random_phase(17, 1'b1);
    reconfigure(9'd3, 9'h105);
    random_phase(17, 1'b0);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reconfigure(9'd300, 9'd1);
    random_phase(17, 1'b0);
    reconfigure(9'd0, 9'd3);
    random_phase(8, 1'b0);
    reconfigure(9'd5, 9'd64);
    random_phase(10, 1'b0);

    wait_idle();
    $display("Sent %0d input transactions and %0d register writes over full, tiny,",
             items_sent, reg_writes, " empty and saturated map shapes;");
    $display("checked %0d query results, %0d of them hits.", queries, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("tilemap_rect_collision_core test passed");
    end else begin
      $display("tilemap_rect_collision_core test failed");
    end
    $finish;
  end

endmodule
